// ===== sv/vap_pkg.sv =====
// Package for the vector angle block: widths, fixed-point constants,
// the CORDIC arctangent table and the structs carried by the pipeline cells.
// No dependencies.
package vap_pkg;

   localparam int COORD_WIDTH_DEF   = 32;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int NORM_TOP   = 23;
   localparam int NW         = NORM_TOP + 1;   // normalized component, signed
   localparam int PW         = 2 * NW;         // one product, signed
   localparam int SW         = PW + 2;         // sum of three products
   localparam int PROD_SHIFT = 17;
   localparam int DW         = 32;             // dot and cross after the shrink
   localparam int QW         = 64;             // square-root remainder and root
   localparam int SQRT_STEPS = QW / 2;
   localparam int XW         = 36;             // CORDIC x and y
   localparam int ZW         = 34;             // CORDIC angle, Q2.30
   localparam int AW         = 15;             // result angle, Q2.13
   localparam int TW         = 14;             // tolerance register

   localparam logic [AW-1:0] ANG_PI_Q13      = 15'd25736;
   localparam logic [AW-1:0] ANG_HALF_PI_Q13 = 15'd12868;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

   localparam int  CSR_AW      = 3;
   localparam logic CSR_IDX_TOL = 1'b0;

   typedef struct packed {
      logic                 valid;
      logic                 degen;
      logic signed [DW-1:0] dot;
      logic [QW-1:0]        rem;
      logic [QW-1:0]        root;
   } sqrt_state_type;

   typedef struct packed {
      logic                 valid;
      logic                 degen;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_state_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] r;
      begin
         case (idx)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837830;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543515;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            11: r = 34'sd524288;
            12: r = 34'sd262144;
            13: r = 34'sd131072;
            14: r = 34'sd65536;
            15: r = 34'sd32768;
            16: r = 34'sd16384;
            17: r = 34'sd8192;
            18: r = 34'sd4096;
            19: r = 34'sd2048;
            20: r = 34'sd1024;
            21: r = 34'sd512;
            22: r = 34'sd256;
            23: r = 34'sd128;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // Sign-magnitude right shift of a product sum, truncating toward zero.
   function automatic logic signed [DW-1:0] shrink(input logic signed [SW-1:0] w);
      logic [SW-1:0] mag;
      logic [SW-1:0] m;
      begin
         mag = w[SW-1] ? SW'(-w) : SW'(w);
         m   = mag >> PROD_SHIFT;
         return w[SW-1] ? -$signed(m[DW-1:0]) : $signed(m[DW-1:0]);
      end
   endfunction

endpackage

// ===== sv/vap_norm.sv =====
// Two-stage normalizer: scales one 3D difference vector so that its largest
// magnitude lies in [2^22, 2^23), and flags the zero vector. Uses vap_pkg.
module vap_norm #(
   parameter int CW = 32
) (
   input  logic                          clock,
   input  logic [2:0][CW:0]              comp,
   output logic [2:0][vap_pkg::NW-1:0]   norm,
   output logic                          is_zero
);
   import vap_pkg::*;

   localparam int MW  = CW + 1;
   localparam int LW  = $clog2(MW + 1);
   localparam int XTW = (MW > NW) ? MW : NW;

   logic [2:0][MW-1:0] mag_in, mag_ff;
   logic [2:0]         neg_ff;
   logic [MW-1:0]      any_bits;
   logic [LW-1:0]      lead_in, lead_ff;
   logic               zero_ff;
   logic [2:0][NW-1:0] norm_in;
   logic [2:0][NW-1:0] norm_ff;
   logic               zero2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = comp[i][MW-1] ? MW'(-$signed(comp[i])) : comp[i];
      end
      // The leading one of the OR of the magnitudes is that of the largest one.
      any_bits = mag_in[0] | mag_in[1] | mag_in[2];
      lead_in  = '0;
      for (int k = 0; k < MW; k++) begin
         if (any_bits[k]) begin
            lead_in = LW'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= {comp[2][MW-1], comp[1][MW-1], comp[0][MW-1]};
      lead_ff <= lead_in;
      zero_ff <= (any_bits == '0);
   end

   always_comb begin
      logic [XTW-1:0] t;
      for (int i = 0; i < 3; i++) begin
         t = XTW'(mag_ff[i]);
         if (lead_ff >= LW'(NORM_TOP - 1)) begin
            t = t >> (lead_ff - LW'(NORM_TOP - 1));
         end else begin
            t = t << (LW'(NORM_TOP - 1) - lead_ff);
         end
         norm_in[i] = neg_ff[i] ? NW'(-$signed({1'b0, t[NW-2:0]}))
                                : {1'b0, t[NW-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      norm_ff  <= norm_in;
      zero2_ff <= zero_ff;
   end

   assign norm    = norm_ff;
   assign is_zero = zero2_ff;

endmodule

// ===== sv/vap_sqrt_cell.sv =====
// One cell of the square-root chain: resolves one bit of the integer root
// per cycle and hands its state to the next cell. Uses vap_pkg.
module vap_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  vap_pkg::sqrt_state_type         cell_in,
   output vap_pkg::sqrt_state_type         cell_out
);
   import vap_pkg::*;

   localparam logic [QW-1:0] BIT = QW'(1) << (QW - 2 - 2 * STEP);

   sqrt_state_type state_in, state_ff;
   logic [QW-1:0]  trial;

   always_comb begin
      state_in = cell_in;
      trial    = cell_in.root + BIT;
      if (cell_in.rem >= trial) begin
         state_in.rem  = cell_in.rem - trial;
         state_in.root = (cell_in.root >> 1) + BIT;
      end else begin
         state_in.root = cell_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.valid <= 1'b0;
      end else begin
         state_ff.valid <= state_in.valid;
      end
      state_ff.degen <= state_in.degen;
      state_ff.dot   <= state_in.dot;
      state_ff.rem   <= state_in.rem;
      state_ff.root  <= state_in.root;
   end

   assign cell_out = state_ff;

endmodule

// ===== sv/vap_cordic_cell.sv =====
// One CORDIC vectoring cell: a single micro-rotation per cycle toward y = 0,
// accumulating the angle in Q2.30. Uses vap_pkg.
module vap_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vap_pkg::cordic_state_type     cell_in,
   output vap_pkg::cordic_state_type     cell_out
);
   import vap_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = atan_q30(STAGE);

   cordic_state_type     state_in, state_ff;
   logic signed [XW-1:0] xs, ys;

   always_comb begin
      xs       = cell_in.x >>> STAGE;
      ys       = cell_in.y >>> STAGE;
      state_in = cell_in;
      if (!cell_in.y[XW-1]) begin
         state_in.x = cell_in.x + ys;
         state_in.y = cell_in.y - xs;
         state_in.z = cell_in.z + ATAN;
      end else begin
         state_in.x = cell_in.x - ys;
         state_in.y = cell_in.y + xs;
         state_in.z = cell_in.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.valid <= 1'b0;
      end else begin
         state_ff.valid <= state_in.valid;
      end
      state_ff.degen <= state_in.degen;
      state_ff.x     <= state_in.x;
      state_ff.y     <= state_in.y;
      state_ff.z     <= state_in.z;
   end

   assign cell_out = state_ff;

endmodule

// ===== sv/vector_angle_parallel_test.sv =====
// Top level of the vector angle block: differences, normalizers, products,
// square-root and CORDIC cell chains, output stage and register port. Uses vap_pkg.
//
// The block takes one transaction in every cycle; busy is always low. Each
// transaction returns one result, marked by rsp_valid for one cycle, after it
// passes the difference registers, the normalizer stages, the product, sum,
// square and sum-of-squares registers, 32 cells of the square-root chain, the
// register that folds the dot product's sign, one cell per CORDIC stage and
// the output register. Results come in input order and cannot be held off,
// so the receiver must take each one in its cycle.
module vector_angle_parallel_test #(
   parameter int COORD_WIDTH   = vap_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = vap_pkg::CORDIC_STAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [31:0]                  req_origin_x,
   input  logic [31:0]                  req_origin_y,
   input  logic [31:0]                  req_origin_z,
   input  logic [31:0]                  req_first_x,
   input  logic [31:0]                  req_first_y,
   input  logic [31:0]                  req_first_z,
   input  logic [31:0]                  req_second_x,
   input  logic [31:0]                  req_second_y,
   input  logic [31:0]                  req_second_z,
   output logic                         rsp_valid,
   output logic [vap_pkg::AW-1:0]       rsp_angle_value,
   output logic                         rsp_is_parallel,
   output logic                         rsp_degenerate,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [vap_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import vap_pkg::*;

   localparam int CW = COORD_WIDTH;

   // Register port.
   logic [TW-1:0] tol_ff;
   logic          csr_sel_tol;

   assign pready      = 1'b1;
   assign csr_sel_tol = (paddr[2] == CSR_IDX_TOL);
   assign prdata      = csr_sel_tol ? 32'(tol_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (psel && penable && pwrite && pready && csr_sel_tol) begin
         tol_ff <= pwdata[TW-1:0];
      end
   end

   assign busy = 1'b0;

   // Differences.
   logic [2:0][CW-1:0] org, fst, snd;
   logic [2:0][CW:0]   u_in, u_ff, v_in, v_ff;
   logic [3:0]         vld_ff;

   always_comb begin
      org = {req_origin_z[CW-1:0], req_origin_y[CW-1:0], req_origin_x[CW-1:0]};
      fst = {req_first_z[CW-1:0], req_first_y[CW-1:0], req_first_x[CW-1:0]};
      snd = {req_second_z[CW-1:0], req_second_y[CW-1:0], req_second_x[CW-1:0]};
      for (int i = 0; i < 3; i++) begin
         u_in[i] = (CW+1)'($signed(fst[i])) - (CW+1)'($signed(org[i]));
         v_in[i] = (CW+1)'($signed(snd[i])) - (CW+1)'($signed(org[i]));
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      v_ff <= v_in;
   end

   // Valid bits through differences, normalizer and product stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start && !busy};
      end
   end

   logic [2:0][NW-1:0] un, vn;
   logic               u_zero, v_zero;

   vap_norm #(.CW(CW)) u_norm (
      .clock   (clock),
      .comp    (u_ff),
      .norm    (un),
      .is_zero (u_zero)
   );

   vap_norm #(.CW(CW)) v_norm (
      .clock   (clock),
      .comp    (v_ff),
      .norm    (vn),
      .is_zero (v_zero)
   );

   // Nine partial products: three for the dot, six for the cross.
   logic signed [PW-1:0] prod_ff [9];
   logic                 degen_p_ff;

   always_ff @(posedge clock) begin
      prod_ff[0] <= $signed(un[0]) * $signed(vn[0]);
      prod_ff[1] <= $signed(un[1]) * $signed(vn[1]);
      prod_ff[2] <= $signed(un[2]) * $signed(vn[2]);
      prod_ff[3] <= $signed(un[1]) * $signed(vn[2]);
      prod_ff[4] <= $signed(un[2]) * $signed(vn[1]);
      prod_ff[5] <= $signed(un[2]) * $signed(vn[0]);
      prod_ff[6] <= $signed(un[0]) * $signed(vn[2]);
      prod_ff[7] <= $signed(un[0]) * $signed(vn[1]);
      prod_ff[8] <= $signed(un[1]) * $signed(vn[0]);
      degen_p_ff <= u_zero || v_zero;
   end

   // Sums with the shrink, then squares, then the sum of squares.
   logic signed [DW-1:0] dot_ff, cx_ff, cy_ff, cz_ff;
   logic signed [DW-1:0] dot2_ff;
   logic                 degen_s_ff, degen_q_ff;
   logic [QW-1:0]        sqx_ff, sqy_ff, sqz_ff;
   logic [1:0]           vld2_ff;
   sqrt_state_type       chain_head;

   always_ff @(posedge clock) begin
      dot_ff <= shrink(SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]));
      cx_ff  <= shrink(SW'(prod_ff[3]) - SW'(prod_ff[4]));
      cy_ff  <= shrink(SW'(prod_ff[5]) - SW'(prod_ff[6]));
      cz_ff  <= shrink(SW'(prod_ff[7]) - SW'(prod_ff[8]));
      degen_s_ff <= degen_p_ff;

      sqx_ff  <= QW'($signed(cx_ff) * $signed(cx_ff));
      sqy_ff  <= QW'($signed(cy_ff) * $signed(cy_ff));
      sqz_ff  <= QW'($signed(cz_ff) * $signed(cz_ff));
      dot2_ff <= dot_ff;
      degen_q_ff <= degen_s_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff          <= '0;
         chain_head.valid <= 1'b0;
      end else begin
         vld2_ff          <= {vld2_ff[0], vld_ff[3]};
         chain_head.valid <= vld2_ff[1];
      end
      chain_head.rem   <= sqx_ff + sqy_ff + sqz_ff;
      chain_head.root  <= '0;
      chain_head.dot   <= dot2_ff;
      chain_head.degen <= degen_q_ff;
   end

   // Square-root chain.
   sqrt_state_type sq_link [SQRT_STEPS+1];
   assign sq_link[0] = chain_head;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      vap_sqrt_cell #(.STEP(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (sq_link[g]),
         .cell_out (sq_link[g+1])
      );
   end

   // Fold a negative dot product by a quarter turn before the CORDIC chain.
   cordic_state_type cd_link [CORDIC_STAGES+1];
   sqrt_state_type   sq_tail;
   logic signed [XW-1:0] s_ext, d_ext;

   assign sq_tail = sq_link[SQRT_STEPS];
   assign s_ext   = XW'($signed({1'b0, sq_tail.root[DW-1:0]}));
   assign d_ext   = XW'(sq_tail.dot);

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_link[0].valid <= 1'b0;
      end else begin
         cd_link[0].valid <= sq_tail.valid;
      end
      cd_link[0].degen <= sq_tail.degen;
      if (sq_tail.dot[DW-1]) begin
         cd_link[0].x <= s_ext;
         cd_link[0].y <= -d_ext;
         cd_link[0].z <= HALF_PI_Q30;
      end else begin
         cd_link[0].x <= d_ext;
         cd_link[0].y <= s_ext;
         cd_link[0].z <= '0;
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      vap_cordic_cell #(.STAGE(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (cd_link[g]),
         .cell_out (cd_link[g+1])
      );
   end

   // Rounding, clamp, fold and tolerance compare; a degenerate input gives a zero angle.
   cordic_state_type     cd_tail;
   logic signed [ZW-1:0] z_round;
   logic [AW+1:0]        ang_wide;
   logic [AW-1:0]        ang, folded;
   logic                 valid_ff, par_ff, degen_ff;
   logic [AW-1:0]        angle_ff;

   always_comb begin
      cd_tail  = cd_link[CORDIC_STAGES];
      z_round  = cd_tail.z + ZW'(65536);
      ang_wide = z_round[ZW-1:ZW-AW-2];
      if (cd_tail.z[ZW-1] || cd_tail.z == '0) begin
         ang = '0;
      end else if (ang_wide > (AW+2)'(ANG_PI_Q13)) begin
         ang = ANG_PI_Q13;
      end else begin
         ang = ang_wide[AW-1:0];
      end
      folded = (ang > ANG_HALF_PI_Q13) ? ANG_PI_Q13 - ang : ang;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cd_tail.valid;
      end
      if (cd_tail.degen) begin
         angle_ff <= '0;
         par_ff   <= 1'b0;
         degen_ff <= 1'b1;
      end else begin
         angle_ff <= ang;
         par_ff   <= (folded <= AW'(tol_ff));
         degen_ff <= 1'b0;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_angle_value = angle_ff;
   assign rsp_is_parallel = par_ff;
   assign rsp_degenerate  = degen_ff;

endmodule
